// ----- sv/swbt_pkg.sv -----
// types and constants shared by the work/break timer modules
`timescale 1ns / 1ps

package swbt_pkg;

    localparam int W_REM = 23;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_RUN   = 3'd1,
        ST_PAUSE = 3'd2,
        ST_AWAIT = 3'd3,
        ST_DONE  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SEG_NONE  = 2'd0,
        SEG_FOCUS = 2'd1,
        SEG_BREAK = 2'd2
    } t_seg;

    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_START   = 3'd1,
        REQ_PAUSE   = 3'd2,
        REQ_RESUME  = 3'd3,
        REQ_SKIP    = 3'd4,
        REQ_RESET   = 3'd5,
        REQ_CONFIRM = 3'd6
    } t_req;

    typedef enum logic [1:0] {
        CFG_FOCUS  = 2'd0,
        CFG_BREAK  = 2'd1,
        CFG_CYCLES = 2'd2
    } t_cfg_idx;

    localparam logic [W_REM-1:0] C_MS_PER_MIN    = 23'd60000;
    localparam logic [6:0]       C_FOCUS_MAX_MIN = 7'd90;
    localparam logic [4:0]       C_BREAK_MAX_MIN = 5'd30;
    localparam logic [3:0]       C_MAX_CYCLES    = 4'd8;
    localparam logic [W_REM-1:0] C_FOCUS_RST_MS  = 23'd1500000;
    localparam logic [W_REM-1:0] C_BREAK_RST_MS  = 23'd300000;
    localparam logic [3:0]       C_CYCLES_RST    = 4'd4;

    // floor(x / 1000) = (x * C_DIV_MUL) >> C_DIV_SHIFT for any 23-bit x
    localparam logic [23:0]      C_DIV_MUL       = 24'd8589935;
    localparam int               C_DIV_SHIFT     = 33;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  run_status;
        logic [1:0]  segment_kind;
        logic [3:0]  cycle_number;
        logic [12:0] secs_left;
        logic [15:0] sessions_done;
        logic [31:0] revision;
    } t_out_word;

    // segment lengths already scaled to milliseconds, cycle limit already clamped
    typedef struct packed {
        logic [W_REM-1:0] focus_ms;
        logic [W_REM-1:0] break_ms;
        logic [3:0]       cyc_lim;
    } t_cfg;

    typedef struct packed {
        t_status          status;
        t_seg             segment;
        logic [3:0]       cycle;
        logic [W_REM-1:0] rem_ms;
        logic [31:0]      last_ms;
        logic [15:0]      sessions;
        logic [31:0]      revision;
    } t_state;

endpackage

// ----- sv/swbt_step.sv -----
// next-state logic of the timer for one command word
`timescale 1ns / 1ps

module swbt_step
    import swbt_pkg::*;
(
    input  t_state   i_st,
    input  t_cfg     i_cfg,
    input  t_in_word i_cmd,
    output t_state   o_st,
    output logic     o_accepted
);

    // end of the current segment, with or without counting it
    function automatic t_state f_advance(input t_state s, input logic natural, input t_cfg c);
        t_state r;
        r = s;
        case (s.segment)
            SEG_FOCUS: begin
                if (natural) begin
                    r.sessions = s.sessions + 16'd1;
                end
                if (s.cycle >= c.cyc_lim) begin
                    r.status  = ST_DONE;
                    r.segment = SEG_NONE;
                    r.rem_ms  = '0;
                end else begin
                    r.status  = ST_AWAIT;
                    r.segment = SEG_BREAK;
                    r.rem_ms  = c.break_ms;
                end
                r.revision = s.revision + 32'd1;
            end
            SEG_BREAK: begin
                r.cycle    = s.cycle + 4'd1;
                r.status   = ST_AWAIT;
                r.segment  = SEG_FOCUS;
                r.rem_ms   = c.focus_ms;
                r.revision = s.revision + 32'd1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    logic [31:0] elapsed;
    logic        expired;
    logic        tick_adv;
    t_state      ticked;

    // time bookkeeping of a tick, valid whenever the state is running
    always_comb begin
        elapsed       = i_cmd.now_ms - i_st.last_ms;
        expired       = elapsed >= {9'd0, i_st.rem_ms};
        tick_adv      = expired && (i_st.segment != SEG_NONE);
        ticked        = i_st;
        ticked.last_ms = i_cmd.now_ms;
        if (expired) begin
            ticked.rem_ms = '0;
            ticked = f_advance(ticked, 1'b1, i_cfg);
        end else begin
            ticked.rem_ms = i_st.rem_ms - elapsed[W_REM-1:0];
        end
    end

    always_comb begin
        o_st       = i_st;
        o_accepted = 1'b0;
        case (i_cmd.req_type)
            REQ_TICK: begin
                if (i_st.status == ST_RUN) begin
                    o_st       = ticked;
                    o_accepted = tick_adv;
                end
            end
            REQ_START: begin
                if (i_st.status == ST_IDLE) begin
                    o_st.status   = ST_RUN;
                    o_st.segment  = SEG_FOCUS;
                    o_st.cycle    = 4'd1;
                    o_st.rem_ms   = i_cfg.focus_ms;
                    o_st.last_ms  = i_cmd.now_ms;
                    o_st.revision = i_st.revision + 32'd1;
                    o_accepted    = 1'b1;
                end
            end
            REQ_PAUSE: begin
                if (i_st.status == ST_RUN) begin
                    o_st = ticked;
                    if (!tick_adv) begin
                        o_st.status   = ST_PAUSE;
                        o_st.revision = ticked.revision + 32'd1;
                        o_accepted    = 1'b1;
                    end
                end
            end
            REQ_RESUME: begin
                if (i_st.status == ST_PAUSE) begin
                    o_st.status   = ST_RUN;
                    o_st.last_ms  = i_cmd.now_ms;
                    o_st.revision = i_st.revision + 32'd1;
                    o_accepted    = 1'b1;
                end
            end
            REQ_SKIP: begin
                if (i_st.status == ST_RUN) begin
                    if (tick_adv) begin
                        o_st       = ticked;
                        o_accepted = 1'b1;
                    end else begin
                        o_st       = f_advance(ticked, 1'b0, i_cfg);
                        o_accepted = ticked.segment != SEG_NONE;
                    end
                end else if (i_st.status inside {ST_PAUSE, ST_AWAIT}) begin
                    o_st       = f_advance(i_st, 1'b0, i_cfg);
                    o_accepted = i_st.segment != SEG_NONE;
                end
            end
            REQ_RESET: begin
                if (i_st.status != ST_IDLE) begin
                    o_st.status   = ST_IDLE;
                    o_st.segment  = SEG_NONE;
                    o_st.cycle    = 4'd1;
                    o_st.rem_ms   = i_cfg.focus_ms;
                    o_st.last_ms  = '0;
                    o_st.revision = i_st.revision + 32'd1;
                    o_accepted    = 1'b1;
                end
            end
            REQ_CONFIRM: begin
                if (i_st.status == ST_AWAIT) begin
                    o_st.status   = ST_RUN;
                    o_st.rem_ms   = (i_st.segment == SEG_BREAK) ? i_cfg.break_ms
                                                                : i_cfg.focus_ms;
                    o_st.last_ms  = i_cmd.now_ms;
                    o_st.revision = i_st.revision + 32'd1;
                    o_accepted    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- sv/segmented_work_break_timer.sv -----
// top level of the segmented work/break countdown timer
`timescale 1ns / 1ps

// Work/break countdown sequencer. Each input word is one command (tick, start,
// pause, resume, skip, reset, confirm) stamped with a free-running millisecond
// time; every command returns exactly one output word, in order. The block takes
// one word per clock while o_stall is low, and each word passes through three
// registered stages: an input register, the command step (32-bit elapsed
// time, compare and subtract against the remaining time, segment advance), and a
// 23 x 24 constant multiply that turns remaining milliseconds into whole seconds
// ahead of the output register. All three stages hold a word each, so while a
// finished word waits on i_stall the block keeps accepting until the stages
// before it are full. Configuration writes are clamped to their legal range and
// scaled to milliseconds when written, and take effect at the next segment load
// or cycle check; write them only while no command is in flight.

module segmented_work_break_timer
    import swbt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // command channel
    input  logic       i_valid,
    input  t_in_word   i_data,
    output logic       o_stall,
    // result channel
    output logic       o_valid,
    output t_out_word  o_data,
    input  logic       i_stall,
    // configuration writes
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [6:0] i_cfg_data
);

    // word between the command step and the seconds conversion
    typedef struct packed {
        logic             accepted;
        t_status          status;
        t_seg             segment;
        logic [3:0]       cycle;
        logic [W_REM-1:0] rem_ms;
        logic [15:0]      sessions;
        logic [31:0]      revision;
    } t_mid;

    // configuration registers
    t_cfg       r_cfg, n_cfg;
    logic [6:0] cfg_focus_min;
    logic [4:0] cfg_break_min;
    logic [3:0] cfg_cycles;

    // timer state
    t_state r_st, n_st;
    logic   step_ok;

    // pipeline registers
    logic      r_a_valid, n_a_valid;
    t_in_word  r_a_data, n_a_data;
    logic      r_b_valid, n_b_valid;
    t_mid      r_b_word, n_b_word;
    logic      r_c_valid, n_c_valid;
    t_out_word r_c_data, n_c_data;

    logic        a_ready, b_ready, c_ready;
    logic        a_fire, b_fire;
    logic [46:0] sec_prod;

    // ---------------- configuration: clamp and scale at write time
    always_comb begin
        n_cfg         = r_cfg;
        cfg_focus_min = i_cfg_data;
        cfg_break_min = i_cfg_data[4:0];
        cfg_cycles    = i_cfg_data[3:0];
        if (cfg_focus_min == 7'd0) begin
            cfg_focus_min = 7'd1;
        end else if (cfg_focus_min > C_FOCUS_MAX_MIN) begin
            cfg_focus_min = C_FOCUS_MAX_MIN;
        end
        if (cfg_break_min == 5'd0) begin
            cfg_break_min = 5'd1;
        end else if (cfg_break_min > C_BREAK_MAX_MIN) begin
            cfg_break_min = C_BREAK_MAX_MIN;
        end
        if (cfg_cycles == 4'd0) begin
            cfg_cycles = 4'd1;
        end else if (cfg_cycles > C_MAX_CYCLES) begin
            cfg_cycles = C_MAX_CYCLES;
        end
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FOCUS:  n_cfg.focus_ms = W_REM'(cfg_focus_min) * C_MS_PER_MIN;
                CFG_BREAK:  n_cfg.break_ms = W_REM'(cfg_break_min) * C_MS_PER_MIN;
                CFG_CYCLES: n_cfg.cyc_lim  = cfg_cycles;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focus_ms <= C_FOCUS_RST_MS;
            r_cfg.break_ms <= C_BREAK_RST_MS;
            r_cfg.cyc_lim  <= C_CYCLES_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // ---------------- handshake: each stage moves when the next one has room
    assign c_ready = !r_c_valid || !i_stall;
    assign b_ready = !r_b_valid || c_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign a_fire  = r_a_valid && b_ready;
    assign b_fire  = r_b_valid && c_ready;

    assign o_stall = !a_ready;
    assign o_valid = r_c_valid;
    assign o_data  = r_c_data;

    // ---------------- command step, state commits when the word moves on
    swbt_step u_step (
        .i_st       (r_st),
        .i_cfg      (r_cfg),
        .i_cmd      (r_a_data),
        .o_st       (n_st),
        .o_accepted (step_ok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.status   <= ST_IDLE;
            r_st.segment  <= SEG_NONE;
            r_st.cycle    <= 4'd1;
            r_st.rem_ms   <= C_FOCUS_RST_MS;
            r_st.last_ms  <= '0;
            r_st.sessions <= '0;
            r_st.revision <= '0;
        end else if (a_fire) begin
            r_st <= n_st;
        end
    end

    // ---------------- pipeline next values
    // ms to seconds: exact reciprocal multiply for every 23-bit value
    assign sec_prod = 47'(r_b_word.rem_ms) * 47'(C_DIV_MUL);

    always_comb begin
        n_a_valid = r_a_valid;
        n_a_data  = r_a_data;
        n_b_valid = r_b_valid;
        n_b_word  = r_b_word;
        n_c_valid = r_c_valid;
        n_c_data  = r_c_data;
        if (a_ready) begin
            n_a_valid = i_valid;
            n_a_data  = i_data;
        end
        if (b_ready) begin
            n_b_valid = r_a_valid;
        end
        if (a_fire) begin
            n_b_word.accepted = step_ok;
            n_b_word.status   = n_st.status;
            n_b_word.segment  = n_st.segment;
            n_b_word.cycle    = n_st.cycle;
            n_b_word.rem_ms   = n_st.rem_ms;
            n_b_word.sessions = n_st.sessions;
            n_b_word.revision = n_st.revision;
        end
        if (c_ready) begin
            n_c_valid = r_b_valid;
        end
        if (b_fire) begin
            n_c_data.accepted      = r_b_word.accepted;
            n_c_data.run_status    = r_b_word.status;
            n_c_data.segment_kind  = r_b_word.segment;
            n_c_data.cycle_number  = r_b_word.cycle;
            n_c_data.secs_left     = sec_prod[C_DIV_SHIFT+12:C_DIV_SHIFT];
            n_c_data.sessions_done = r_b_word.sessions;
            n_c_data.revision      = r_b_word.revision;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
            r_c_valid <= n_c_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_a_data <= n_a_data;
        r_b_word <= n_b_word;
        r_c_data <= n_c_data;
    end

    // ---------------- checks
    // a finished session has no segment and no time left
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.status == ST_DONE |-> r_st.segment == SEG_NONE && r_st.rem_ms == '0)
        else $error("complete state with a live segment or time left");

    // running, paused or awaiting always has a segment, idle and done never do
    a_seg_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.status == ST_IDLE || r_st.status == ST_DONE) == (r_st.segment == SEG_NONE))
        else $error("segment does not match run status");

    // revision and session count only move with a stepped word
    a_rev_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !a_fire |=> $stable(r_st.revision) && $stable(r_st.sessions))
        else $error("state counters changed without a command");

    // a word waiting for the output register keeps its place and value
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && r_b_valid && !c_ready |=> r_b_valid && $stable(r_b_word))
        else $error("middle stage word lost while output stalled");

endmodule

// ----- tb/sv/swbt_command_checker.sv -----
// checker for the work/break timer: predicts every result word and compares it
`timescale 1ns / 1ps

module swbt_command_checker
    import swbt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  logic       i_cmd_stall,
    input  t_in_word   i_cmd_word,
    input  logic       i_res_valid,
    input  logic       i_res_stall,
    input  t_out_word  i_res_word,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [6:0] i_cfg_data,
    input  logic       i_end,
    output int         o_pending,
    output int         o_errors,
    output int         o_results
);

    localparam int FOCUS_MAX_MIN = 90;
    localparam int BREAK_MAX_MIN = 30;
    localparam int CYCLE_MAX     = 8;
    localparam int MS_PER_MIN    = 60000;
    localparam int MS_PER_SEC    = 1000;
    localparam int PRINT_CAP     = 100;

    // raw register contents, clamped only where they are used
    logic [6:0] m_focus;
    logic [4:0] m_break;
    logic [3:0] m_cycles;

    t_status          st;
    t_seg             seg;
    logic [3:0]       cyc;
    logic [W_REM-1:0] rem_ms;
    logic [31:0]      last_ms;
    logic [15:0]      sessions;
    logic [31:0]      rev;

    t_out_word pending_results[$];

    initial begin
        o_pending = 0;
        o_errors  = 0;
        o_results = 0;
    end

    task automatic report(input string msg);
        if (o_errors < PRINT_CAP) begin
            $display("%0t ns checker: %s", $time, msg);
        end
        o_errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report($sformatf("word %0d %s: got 0x%0h, want 0x%0h",
                             o_results, name, got, want));
        end
    endtask

    function automatic logic [W_REM-1:0] seg_len_ms(input t_seg s);
        int m;
        if (s == SEG_BREAK) begin
            m = (m_break == 0) ? 1 : (m_break > BREAK_MAX_MIN) ? BREAK_MAX_MIN : m_break;
        end else begin
            m = (m_focus == 0) ? 1 : (m_focus > FOCUS_MAX_MIN) ? FOCUS_MAX_MIN : m_focus;
        end
        return W_REM'(m * MS_PER_MIN);
    endfunction

    function automatic logic [3:0] cycle_limit();
        if (m_cycles == 0) return 4'd1;
        if (m_cycles > CYCLE_MAX) return 4'(CYCLE_MAX);
        return m_cycles;
    endfunction

    task automatic go_idle();
        st      = ST_IDLE;
        seg     = SEG_NONE;
        cyc     = 4'd1;
        rem_ms  = seg_len_ms(SEG_FOCUS);
        last_ms = '0;
    endtask

    task automatic next_segment(input bit natural, output bit moved);
        moved = 1'b1;
        case (seg)
            SEG_FOCUS: begin
                if (natural) sessions = sessions + 16'd1;
                if (cyc >= cycle_limit()) begin
                    st     = ST_DONE;
                    seg    = SEG_NONE;
                    rem_ms = '0;
                end else begin
                    st     = ST_AWAIT;
                    seg    = SEG_BREAK;
                    rem_ms = seg_len_ms(SEG_BREAK);
                end
            end
            SEG_BREAK: begin
                cyc    = cyc + 4'd1;
                st     = ST_AWAIT;
                seg    = SEG_FOCUS;
                rem_ms = seg_len_ms(SEG_FOCUS);
            end
            default: moved = 1'b0;
        endcase
        if (moved) rev = rev + 32'd1;
    endtask

    // subtract wrapped elapsed time, advance on expiry
    task automatic run_tick(input logic [31:0] now, output bit moved);
        logic [31:0] dt;
        moved = 1'b0;
        if (st != ST_RUN) return;
        dt      = now - last_ms;
        last_ms = now;
        if (dt >= 32'(rem_ms)) begin
            rem_ms = '0;
            next_segment(1'b1, moved);
        end else begin
            rem_ms = rem_ms - dt[W_REM-1:0];
        end
    endtask

    task automatic apply_command(input t_in_word w, output t_out_word r);
        bit ok;
        bit moved;
        ok = 1'b0;
        case (w.req_type)
            REQ_TICK: run_tick(w.now_ms, ok);
            REQ_START: begin
                if (st == ST_IDLE) begin
                    st      = ST_RUN;
                    seg     = SEG_FOCUS;
                    cyc     = 4'd1;
                    rem_ms  = seg_len_ms(SEG_FOCUS);
                    last_ms = w.now_ms;
                    rev     = rev + 32'd1;
                    ok      = 1'b1;
                end
            end
            REQ_PAUSE: begin
                if (st == ST_RUN) begin
                    run_tick(w.now_ms, moved);
                    if (st == ST_RUN) begin
                        st  = ST_PAUSE;
                        rev = rev + 32'd1;
                        ok  = 1'b1;
                    end
                end
            end
            REQ_RESUME: begin
                if (st == ST_PAUSE) begin
                    st      = ST_RUN;
                    last_ms = w.now_ms;
                    rev     = rev + 32'd1;
                    ok      = 1'b1;
                end
            end
            REQ_SKIP: begin
                if (st == ST_RUN || st == ST_PAUSE || st == ST_AWAIT) begin
                    // an expiry on the way in counts as the skip itself
                    if (st == ST_RUN) begin
                        run_tick(w.now_ms, moved);
                        if (st != ST_RUN) ok = 1'b1;
                    end
                    if (!ok) next_segment(1'b0, ok);
                end
            end
            REQ_RESET: begin
                if (st != ST_IDLE) begin
                    go_idle();
                    rev = rev + 32'd1;
                    ok  = 1'b1;
                end
            end
            REQ_CONFIRM: begin
                if (st == ST_AWAIT) begin
                    st      = ST_RUN;
                    rem_ms  = seg_len_ms(seg);
                    last_ms = w.now_ms;
                    rev     = rev + 32'd1;
                    ok      = 1'b1;
                end
            end
            default: ;
        endcase
        r.accepted      = ok;
        r.run_status    = st;
        r.segment_kind  = seg;
        r.cycle_number  = cyc;
        r.secs_left     = 13'(rem_ms / MS_PER_SEC);
        r.sessions_done = sessions;
        r.revision      = rev;
    endtask

    always @(posedge i_clk) begin : watch
        t_out_word want;
        t_out_word got;
        if (!i_rst_n) begin
            m_focus  = 7'd25;
            m_break  = 5'd5;
            m_cycles = 4'd4;
            sessions = '0;
            rev      = '0;
            go_idle();
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FOCUS:  m_focus  = i_cfg_data;
                    CFG_BREAK:  m_break  = i_cfg_data[4:0];
                    CFG_CYCLES: m_cycles = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall) begin
                got = i_res_word;
                if (pending_results.size() == 0) begin
                    report($sformatf("result word 0x%0h with nothing pending", got));
                end else begin
                    want = pending_results.pop_front();
                    check_field("accepted", got.accepted, want.accepted);
                    check_field("run_status", got.run_status, want.run_status);
                    check_field("segment_kind", got.segment_kind, want.segment_kind);
                    check_field("cycle_number", got.cycle_number, want.cycle_number);
                    check_field("secs_left", got.secs_left, want.secs_left);
                    check_field("sessions_done", got.sessions_done, want.sessions_done);
                    check_field("revision", got.revision, want.revision);
                end
                o_results++;
            end
            if (i_cmd_valid && !i_cmd_stall) begin
                apply_command(i_cmd_word, want);
                pending_results.push_back(want);
            end
            if (i_end && pending_results.size() != 0) begin
                report($sformatf("%0d result words never arrived", pending_results.size()));
                pending_results.delete();
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

// ----- tb/sv/tb_segmented_work_break_timer.sv -----
// testbench top for the work/break timer: reset, stimulus, flow control, verdict
`timescale 1ns / 1ps

module tb_segmented_work_break_timer;
    import swbt_pkg::*;

    localparam int WATCHDOG_LIMIT   = 5000;  // quiet cycles before giving up
    localparam int HOLD_CYCLES      = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES     = 8;     // pipeline is three deep, leave margin
    localparam int RANDOM_PER_PHASE = 222;
    localparam int NUM_PHASES       = 8;

    // codes the package has no name for
    localparam logic [2:0] REQ_UNUSED     = 3'd7;
    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cmd_valid  = 1'b0;
    t_in_word   cmd_word   = '0;
    logic       cmd_stall;
    logic       res_valid;
    t_out_word  res_word;
    logic       res_stall  = 1'b0;
    logic       cfg_we     = 1'b0;
    logic [1:0] cfg_idx    = '0;
    logic [6:0] cfg_data   = '0;
    logic       check_end  = 1'b0;

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_requests = 0;
    int          words_sent    = 0;
    logic [31:0] clock_ms      = '0;   // free-running millisecond cursor

    int errors;
    int pending;
    int results;

    initial begin
        forever #5 clk = ~clk;
    end

    segmented_work_break_timer u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (cmd_valid),
        .i_data     (cmd_word),
        .o_stall    (cmd_stall),
        .o_valid    (res_valid),
        .o_data     (res_word),
        .i_stall    (res_stall),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    swbt_command_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd_stall (cmd_stall),
        .i_cmd_word  (cmd_word),
        .i_res_valid (res_valid),
        .i_res_stall (res_stall),
        .i_res_word  (res_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_end       (check_end),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_results   (results)
    );

    // result side: random stall, or a long hold-off when the sender asks for one;
    // the sender keeps offering words meanwhile so the block fills and stalls
    initial begin : receiver
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                res_stall <= 1'b1;
            end else if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES - 1;
                res_stall  <= 1'b1;
            end else begin
                res_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // ends the run when no word moves on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // offer one command word; random idle cycles first, then hold it until taken.
    // valid is only lowered inside the idle loop and in settle, both of which advance time
    task automatic send_cmd(input logic [2:0] req, input logic [31:0] stamp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= '{req_type: req, now_ms: stamp};
        do @(posedge clk); while (cmd_stall);
        words_sent++;
    endtask

    // wait until every word in flight has come back, so registers may change
    task automatic settle();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [6:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    // all three registers plus a write to the unused index, which must be ignored
    task automatic load_settings(input logic [6:0] focus, input logic [6:0] brk,
                                 input logic [6:0] cycles);
        cfg_write(CFG_FOCUS, focus);
        cfg_write(CFG_BREAK, brk);
        cfg_write(CFG_CYCLES, cycles);
        cfg_write(CFG_UNUSED_IDX, 7'($urandom_range(0, 127)));
        cfg_we <= 1'b0;
    endtask

    // mostly small steps so segments run down, sometimes long jumps that
    // expire anything, and now and then a jump anywhere in the 32-bit range
    function automatic logic [31:0] advance_clock();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)      clock_ms += $urandom_range(0, 20000);
        else if (pick < 72) clock_ms += $urandom_range(0, 120000);
        else if (pick < 88) clock_ms += $urandom_range(0, 6000000);
        else if (pick < 94) clock_ms += 0;
        else                clock_ms = $urandom;
        return clock_ms;
    endfunction

    // weighted toward ticks and confirms so sessions actually progress;
    // reset is rare so long cycle counts can reach completion
    function automatic logic [2:0] pick_request();
        int p;
        p = $urandom_range(0, 99);
        if (p < 42) return REQ_TICK;
        if (p < 50) return REQ_START;
        if (p < 57) return REQ_PAUSE;
        if (p < 65) return REQ_RESUME;
        if (p < 73) return REQ_SKIP;
        if (p < 75) return REQ_RESET;
        if (p < 92) return REQ_CONFIRM;
        if (p < 95) return REQ_UNUSED;
        return REQ_TICK;
    endfunction

    // hand-built walk through one default session (25 min focus, 5 min break)
    task automatic directed_walk();
        logic [31:0] t0;
        logic [31:0] t1;
        t0 = 32'hFFFF_FC18;
        t1 = 32'h8000_0000;
        // every command but start is rejected from idle, the unused code too
        send_cmd(REQ_TICK, 32'h0000_0000);
        send_cmd(REQ_PAUSE, 32'h0000_0000);
        send_cmd(REQ_RESUME, 32'h0000_0000);
        send_cmd(REQ_SKIP, 32'h0000_0000);
        send_cmd(REQ_RESET, 32'h0000_0000);
        send_cmd(REQ_CONFIRM, 32'hFFFF_FFFF);
        send_cmd(REQ_UNUSED, 32'hFFFF_FFFF);
        // start just before the millisecond counter wraps
        send_cmd(REQ_START, t0);
        send_cmd(REQ_START, t0 + 5);            // already running
        send_cmd(REQ_TICK, t0 + 1500);          // elapsed across the wrap
        send_cmd(REQ_PAUSE, t0 + 2000);
        send_cmd(REQ_TICK, t0 + 9000);          // paused, no time taken
        send_cmd(REQ_PAUSE, t0 + 9000);         // already paused
        send_cmd(REQ_RESUME, t1);
        send_cmd(REQ_TICK, t1 + 498000);        // 1000000 ms left
        send_cmd(REQ_TICK, t1 + 498000);        // zero elapsed
        send_cmd(REQ_TICK, t1 + 1497999);       // 1 ms left shows as zero seconds
        send_cmd(REQ_TICK, t1 + 1498000);       // elapsed equals remaining: expiry
        send_cmd(REQ_TICK, t1 + 1600000);       // awaiting, tick ignored
        send_cmd(REQ_CONFIRM, 32'h1234_5678);   // break runs
        send_cmd(REQ_SKIP, 32'h1234_5682);      // skip while running, no expiry
        send_cmd(REQ_CONFIRM, 32'h2000_0000);
        send_cmd(REQ_PAUSE, 32'h1FFF_FFFF);     // maximum elapsed: pause loses to expiry
        send_cmd(REQ_SKIP, 32'h2000_0100);      // skip from awaiting
        send_cmd(REQ_CONFIRM, 32'h4000_0000);
        send_cmd(REQ_SKIP, 32'h3000_0000);      // expiry on the way in counts as the skip
        send_cmd(REQ_RESET, 32'h3000_0000);     // sessions survive reset
        clock_ms = 32'h3000_0000;
    endtask

    initial begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            // register settings: reset values, both extremes, out-of-range
            // values on both sides, a short fixed session, and random ones
            case (ph)
                0: ;
                1: load_settings(7'd1, 7'd1, 7'd1);
                2: load_settings(7'd90, 7'd30, 7'd8);
                3: load_settings(7'd0, 7'd0, 7'd0);
                4: load_settings(7'd127, 7'd127, 7'd127);
                5: load_settings(7'($urandom_range(1, 90)), 7'($urandom_range(0, 127)),
                                 7'($urandom_range(1, 8)));
                6: load_settings(7'd3, 7'd2, 7'd2);
                default: load_settings(7'($urandom_range(0, 127)),
                                       7'($urandom_range(0, 127)),
                                       7'($urandom_range(0, 127)));
            endcase
            // flow-control mix: none, sender idle, receiver stall, both
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 84; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 84; end
                default: begin send_idle_pct = 38; stall_pct = 38; end
            endcase
            if (ph == 0) directed_walk();
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if ((ph == 1 || ph == 4) && n == 40) hold_requests++;
                send_cmd(pick_request(), advance_clock());
            end
        end

        settle();
        check_end <= 1'b1;
        @(posedge clk);
        @(posedge clk);
        $display("covered %0d command words over %0d register settings and four flow-control mixes",
                 words_sent, NUM_PHASES);
        $display("%0d result words compared, %0d mismatches", results, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
